// File: sv/charlieplex_pwm_scanner_top_defines.svh
// Assertion macros shared by the charlieplex PWM scanner RTL.
`ifndef CHARLIEPLEX_PWM_SCANNER_TOP_DEFINES_SVH
`define CHARLIEPLEX_PWM_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define CPX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define CPX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cpx_pkg.sv
// Shared types and constants of the charlieplex PWM scanner.
package cpx_pkg;

  // Input word kinds carried on the slave tuser.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SWAP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_NUM_LEDS = 1'b0,
    CFG_SCAN_EN  = 1'b1
  } cfg_idx_t;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 4;   // wide enough for a row or lane at the largest pin count
  localparam int COLUMN_W    = 4;
  localparam int SLOT_W      = 8;
  localparam int PINS_W      = 16;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 48;
  localparam logic [7:0] NUM_LEDS_RESET = 8'd56;

  // Write and swap controls from the sequencer to the frame store.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_row;
    logic [ADDR_W-1:0] wr_lane;
    logic [BYTE_W-1:0] wr_data;
    logic              swap;
  } store_ctrl_t;

endpackage

// File: sv/cpx_frame_store.sv
// Double-buffered brightness store, one small array per lane and bank.
module cpx_frame_store #(
  parameter int NUM_PINS = 8,
  localparam int LANES   = NUM_PINS - 1,
  localparam int COL_W   = $clog2(NUM_PINS),
  localparam int LANE_W  = $clog2(LANES)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cpx_pkg::store_ctrl_t     ctrl,
  input  logic [COL_W-1:0]         rd_row,
  output logic [LANES*8-1:0]       rd_data
);

  logic       front_sel;
  logic       rd_bank;
  logic [7:0] bank [2][LANES][NUM_PINS];

  // A swap on this cycle already shows the new front bank to the reader.
  assign rd_bank = front_sel ^ ctrl.swap;

  // Bank select, writes into the back bank, and clearing at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_sel <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int j = 0; j < LANES; j++) begin
          for (int k = 0; k < NUM_PINS; k++) begin
            bank[b][j][k] <= '0;
          end
        end
      end
    end else begin
      if (ctrl.swap) begin
        front_sel <= ~front_sel;
      end
      if (ctrl.wr_en) begin
        bank[~front_sel][ctrl.wr_lane[LANE_W-1:0]][ctrl.wr_row[COL_W-1:0]] <= ctrl.wr_data;
      end
    end
  end

  // The whole row of the active column, one byte per lane.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      rd_data[j*8 +: 8] = bank[rd_bank][j][rd_row];
    end
  end

endmodule

// File: sv/cpx_pin_drive.sv
// Per-pin PWM compare for the active column of the charlieplexed matrix.
module cpx_pin_drive #(
  parameter int NUM_PINS = 8,
  parameter int PWM_BITS = 8,
  localparam int LANES   = NUM_PINS - 1,
  localparam int COL_W   = $clog2(NUM_PINS),
  localparam int LANE_W  = $clog2(LANES),
  localparam int SHIFT   = 8 - PWM_BITS
) (
  input  logic [LANES*8-1:0]  row_data,
  input  logic [COL_W-1:0]    col,
  input  logic [PWM_BITS-1:0] slot,
  input  logic [7:0]          num_leds,
  output logic [NUM_PINS-1:0] levels
);

  logic [7:0] level;
  logic [7:0] base;

  // Brightness threshold of this slot and the first LED position of the column.
  assign level = 8'(slot) << SHIFT;
  assign base  = 8'(col * LANES);

  // A pin other than the column is pulled low when its LED is fitted and lit.
  always_comb begin
    logic [LANE_W-1:0] lane;
    logic [7:0]        pos;
    logic              lit;
    lane = '0;
    pos  = '0;
    lit  = 1'b0;
    for (int r = 0; r < NUM_PINS; r++) begin
      if (r == int'(col)) begin
        levels[r] = 1'b1;
      end else begin
        lane      = (r < int'(col)) ? LANE_W'(r) : LANE_W'(r - 1);
        pos       = base + 8'(lane);
        lit       = (pos < num_leds) && (row_data[lane*8 +: 8] > level);
        levels[r] = ~lit;
      end
    end
  end

endmodule

// File: sv/charlieplex_pwm_scanner_top.sv
// Top level of the charlieplex PWM scanner: sequencer, registers and assertions.
//
//   Channel  | Direction | Contents
//   s_axis   | in        | tdata: led_index, brightness; tuser: func
//   m_axis   | out       | tdata: column, slot, pin_level, push_pull_mask; tlast: column_end
//   cfg      | in        | cfg_we, cfg_index, cfg_data (num_leds, scan_enable)
//
// One input word is taken every clock while no tick is held; a tick is captured in the
// input register at the accepting edge, and its result moves to the result register once that is free.
// Writes and swaps take no output slot and pass even while a result waits.
// A tick waits in the input register only while the result register is full and
// not taken. Reset clears both frame banks, counters and the swap request at once.
`include "charlieplex_pwm_scanner_top_defines.svh"

module charlieplex_pwm_scanner_top #(
  parameter int NUM_PINS = 8,
  parameter int PWM_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cpx_pkg::S_TDATA_W-1:0]       s_axis_tdata,   // led_index, brightness
  input  logic [cpx_pkg::FUNC_W-1:0]          s_axis_tuser,   // func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // column, slot, pin_level, push_pull_mask, zero fill
  output logic [cpx_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,   // column_end
  input  logic                                cfg_we,
  input  logic [cpx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int LANES = NUM_PINS - 1;
  localparam int COL_W = $clog2(NUM_PINS);
  localparam int DEPTH = NUM_PINS * LANES;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(NUM_PINS - 1);
  localparam int PP_LO = cpx_pkg::COLUMN_W + cpx_pkg::SLOT_W + cpx_pkg::PINS_W;

  // Input register.
  logic                in_valid;
  cpx_pkg::func_t      in_func;
  logic [7:0]          in_index;
  logic [7:0]          in_bright;

  // Configuration and scan state.
  logic [7:0]          num_leds;
  logic                scan_en;
  logic [COL_W-1:0]    col_cnt;
  logic [PWM_BITS-1:0] slot_cnt;
  logic                swap_pending;

  // Result register.
  logic                                out_valid;
  logic [cpx_pkg::M_TDATA_W-1:0]       out_data;
  logic                                out_last;

  logic                  is_tick;
  logic                  exec;
  logic                  tick_go;
  logic                  tick_run;
  logic                  slot_last;
  logic                  do_swap;
  logic                  swap_req;
  logic                  wr_req;
  logic [cpx_pkg::ADDR_W-1:0] wr_row;
  cpx_pkg::store_ctrl_t  ctrl;
  logic [LANES*8-1:0]    row_data;
  logic [NUM_PINS-1:0]   levels;
  logic [cpx_pkg::PINS_W-1:0]   pin_level;
  logic [cpx_pkg::PINS_W-1:0]   pp_mask;
  logic [cpx_pkg::M_TDATA_W-1:0] result;

  // Handshake: a tick needs a free result register, other words never wait.
  assign is_tick       = (in_func == cpx_pkg::FUNC_TICK);
  assign exec          = in_valid && (!is_tick || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || exec;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  // Decode of the word being executed.
  always_comb begin
    wr_req   = 1'b0;
    swap_req = 1'b0;
    tick_go  = 1'b0;
    unique case (in_func)
      cpx_pkg::FUNC_WRITE: wr_req   = exec;
      cpx_pkg::FUNC_SWAP:  swap_req = exec;
      cpx_pkg::FUNC_TICK:  tick_go  = exec;
      default: ;
    endcase
  end

  assign tick_run  = tick_go && scan_en;
  assign slot_last = (slot_cnt == {PWM_BITS{1'b1}});
  assign do_swap   = tick_run && (slot_cnt == '0) && swap_pending;

  // Split a LED position into row (column) and lane by comparing with row starts.
  always_comb begin
    wr_row = '0;
    for (int k = 1; k < NUM_PINS; k++) begin
      if (in_index >= 8'(k * LANES)) begin
        wr_row = cpx_pkg::ADDR_W'(k);
      end
    end
  end

  assign ctrl.wr_en   = wr_req && (in_index < 8'(DEPTH));
  assign ctrl.wr_row  = wr_row;
  assign ctrl.wr_lane = cpx_pkg::ADDR_W'(in_index - 8'(wr_row * LANES));
  assign ctrl.wr_data = in_bright;
  assign ctrl.swap    = do_swap;

  cpx_frame_store #(
    .NUM_PINS (NUM_PINS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_row  (col_cnt),
    .rd_data (row_data)
  );

  cpx_pin_drive #(
    .NUM_PINS (NUM_PINS),
    .PWM_BITS (PWM_BITS)
  ) u_drive (
    .row_data (row_data),
    .col      (col_cnt),
    .slot     (slot_cnt),
    .num_leds (num_leds),
    .levels   (levels)
  );

  // Result word; a disabled scan releases every pin and drives none.
  assign pin_level = scan_en ? cpx_pkg::PINS_W'(levels)
                             : cpx_pkg::PINS_W'({NUM_PINS{1'b1}});
  assign pp_mask   = scan_en ? cpx_pkg::PINS_W'(1 << col_cnt) : '0;
  assign result    = {4'b0000, pp_mask, pin_level,
                      cpx_pkg::SLOT_W'(slot_cnt), cpx_pkg::COLUMN_W'(col_cnt)};

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func   <= cpx_pkg::func_t'(s_axis_tuser);
      in_index  <= s_axis_tdata[7:0];
      in_bright <= s_axis_tdata[15:8];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_leds <= cpx_pkg::NUM_LEDS_RESET;
      scan_en  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cpx_pkg::cfg_idx_t'(cfg_index))
        cpx_pkg::CFG_NUM_LEDS: num_leds <= cfg_data;
        cpx_pkg::CFG_SCAN_EN:  scan_en  <= cfg_data[0];
      endcase
    end
  end

  // Slot and column counters and the pending swap.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt      <= '0;
      slot_cnt     <= '0;
      swap_pending <= 1'b0;
    end else begin
      if (swap_req) begin
        swap_pending <= 1'b1;
      end else if (do_swap) begin
        swap_pending <= 1'b0;
      end
      if (tick_run) begin
        if (slot_last) begin
          slot_cnt <= '0;
          col_cnt  <= (col_cnt == COL_MAX) ? '0 : col_cnt + 1'b1;
        end else begin
          slot_cnt <= slot_cnt + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      out_data <= result;
      out_last <= scan_en && slot_last;
    end
  end

  // Checks on the scan sequencer.
  `CPX_ASSERT_NXT(a_slot_step, tick_run && !slot_last, slot_cnt == $past(slot_cnt) + 1'b1, "slot did not advance")
  `CPX_ASSERT_NXT(a_col_wrap, tick_run && slot_last, (slot_cnt == '0) && (col_cnt == (($past(col_cnt) == COL_MAX) ? '0 : $past(col_cnt) + 1'b1)), "column did not advance at slot wrap")
  `CPX_ASSERT_NXT(a_swap_once, do_swap, !swap_pending, "swap request not cleared by exchange")
  `CPX_ASSERT_IMP(a_pp_onehot, out_valid, $onehot0(out_data[PP_LO +: cpx_pkg::PINS_W]), "push-pull mask not one-hot")

endmodule

// File: verif/cpx_scan_checker.sv
// Scoreboard for the charlieplex PWM scanner: tracks the stream and config ports and checks results.
module cpx_scan_checker
  import cpx_pkg::*;
#(
  parameter int NUM_PINS = 8,
  parameter int PWM_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // led_index, brightness
  input  logic [FUNC_W-1:0]    s_axis_tuser,   // func
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // column, slot, pin_level, push_pull_mask, zero fill
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tlast,   // column_end
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   words_outstanding,
  output int                   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = NUM_PINS * (NUM_PINS - 1);
  localparam int LAST_SLOT   = (1 << PWM_BITS) - 1;
  localparam int PIN_ALL     = (1 << NUM_PINS) - 1;
  localparam int SLOT_LSB    = COLUMN_W;
  localparam int LEVEL_LSB   = SLOT_LSB + SLOT_W;
  localparam int MASK_LSB    = LEVEL_LSB + PINS_W;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [SLOT_W-1:0]   slot;
    logic [PINS_W-1:0]   pin_level;
    logic [PINS_W-1:0]   drive_mask;
    logic                column_end;
  } scan_word_t;

  // Shadow copy of the scanner state and its registers.
  logic [BYTE_W-1:0]   front_bank [STORE_DEPTH];
  logic [BYTE_W-1:0]   back_bank  [STORE_DEPTH];
  logic [COLUMN_W-1:0] column_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                swap_req;
  logic [7:0]          led_count;
  logic                scan_on;

  scan_word_t expected_words[$];
  int         fail_total;
  int         checked_total;

  // Works out the result word of one tick and moves the scan on.
  function automatic scan_word_t scan_tick();
    scan_word_t        w;
    int                col;
    int                pos;
    logic [BYTE_W-1:0] level;
    logic [BYTE_W-1:0] held;
    w.column     = column_q;
    w.slot       = slot_q;
    w.pin_level  = PINS_W'(PIN_ALL);
    w.drive_mask = '0;
    w.column_end = 1'b0;
    if (!scan_on) begin
      return w;
    end
    // A pending swap lands only as a column starts.
    if (slot_q == '0 && swap_req) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        held          = front_bank[i];
        front_bank[i] = back_bank[i];
        back_bank[i]  = held;
      end
      swap_req = 1'b0;
    end
    col   = column_q;
    level = BYTE_W'((int'(slot_q) << (8 - PWM_BITS)) & 8'hff);
    for (int r = 0; r < NUM_PINS; r++) begin
      if (r != col) begin
        pos = col * (NUM_PINS - 1) + (r < col ? r : r - 1);
        if (pos < int'(led_count) && pos < STORE_DEPTH && front_bank[pos] > level) begin
          w.pin_level[r] = 1'b0;
        end
      end
    end
    w.drive_mask = PINS_W'(1) << col;
    w.column_end = (int'(slot_q) == LAST_SLOT);
    if (w.column_end) begin
      slot_q   = '0;
      column_q = COLUMN_W'((col + 1) % NUM_PINS);
    end else begin
      slot_q = slot_q + 1'b1;
    end
    return w;
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      fail_total++;
      if (fail_total <= REPORT_MAX) begin
        $display("%0t ns: result word %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, checked_total, name, want_v, got_v);
      end
    end
  endfunction

  // Result words are checked before the same edge's input word is predicted.
  always @(posedge clk) begin
    scan_word_t got;
    scan_word_t want;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        front_bank[i] = '0;
        back_bank[i]  = '0;
      end
      column_q  = '0;
      slot_q    = '0;
      swap_req  = 1'b0;
      led_count = NUM_LEDS_RESET;
      scan_on   = 1'b1;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.column     = m_axis_tdata[0 +: COLUMN_W];
        got.slot       = m_axis_tdata[SLOT_LSB +: SLOT_W];
        got.pin_level  = m_axis_tdata[LEVEL_LSB +: PINS_W];
        got.drive_mask = m_axis_tdata[MASK_LSB +: PINS_W];
        got.column_end = m_axis_tlast;
        if (expected_words.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX) begin
            $display("%0t ns: result word with no tick waiting: tdata 0x%0h, tlast %0b",
                     $time, m_axis_tdata, m_axis_tlast);
          end
        end else begin
          want = expected_words.pop_front();
          check_field("column", 16'(want.column), 16'(got.column));
          check_field("slot", 16'(want.slot), 16'(got.slot));
          check_field("pin_level", want.pin_level, got.pin_level);
          check_field("push_pull_mask", want.drive_mask, got.drive_mask);
          check_field("column_end", 16'(want.column_end), 16'(got.column_end));
        end
        checked_total++;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_LEDS: led_count = cfg_data;
          CFG_SCAN_EN:  scan_on   = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          FUNC_WRITE: begin
            if (int'(s_axis_tdata[7:0]) < STORE_DEPTH) begin
              back_bank[s_axis_tdata[7:0]] = s_axis_tdata[15:8];
            end
          end
          FUNC_SWAP: swap_req = 1'b1;
          FUNC_TICK: expected_words.push_back(scan_tick());
          default: ;
        endcase
      end
    end
    mismatches        <= fail_total;
    words_outstanding <= expected_words.size();
    words_checked     <= checked_total;
  end

  initial begin
    fail_total    = 0;
    checked_total = 0;
  end

endmodule

// File: verif/tb_charlieplex_pwm_scanner_top.sv
// Testbench top for the charlieplex PWM scanner: clock, reset, stimulus and verdict.
module tb_charlieplex_pwm_scanner_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpx_pkg::*;

  localparam int NUM_PINS       = 8;
  localparam int PWM_BITS       = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  // Spare func code that the block must ignore.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_THREE_OF_FOUR,
    RX_COIN,
    RX_BLOCKS
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // led_index, brightness
  logic [FUNC_W-1:0]    s_axis_tuser = '0;   // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // column, slot, pin_level, push_pull_mask, zero fill
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;        // column_end
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int       mismatches;
  int       words_outstanding;
  int       words_checked;
  int       items_sent = 0;
  int       ticks_sent = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  logic [7:0] stall_phase = '0;
  rx_mode_t   rx_mode = RX_OPEN;

  always #10 clk = ~clk;

  charlieplex_pwm_scanner_top #(
    .NUM_PINS (NUM_PINS),
    .PWM_BITS (PWM_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cpx_scan_checker #(
    .NUM_PINS (NUM_PINS),
    .PWM_BITS (PWM_BITS)
  ) scan_check (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tlast      (m_axis_tlast),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .words_outstanding (words_outstanding),
    .words_checked     (words_checked)
  );

  // Result sink: the stall pattern is picked anew at random whenever the low seven bits of the phase wrap.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_phase   <= '0;
      rx_mode       <= RX_OPEN;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase[6:0] == '0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_OPEN:          m_axis_tready <= 1'b1;
        RX_THREE_OF_FOUR: m_axis_tready <= (stall_phase[1:0] != 2'd0);
        RX_COIN:          m_axis_tready <= ($urandom_range(0, 1) == 1);
        default:          m_axis_tready <= ~stall_phase[3];
      endcase
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, words_outstanding);
      $display("tb_charlieplex_pwm_scanner_top: FAIL");
      $finish;
    end
  end

  // Sender pacing: bursts of random length, mostly followed by a random gap.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 4) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_word(input logic [FUNC_W-1:0] kind, input logic [7:0] led_index,
                           input logic [7:0] brightness);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {brightness, led_index};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (kind == FUNC_TICK) begin
      ticks_sent++;
    end
    pace_sender();
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender until every tick has produced its word, then lets the pipe settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Most writes land on the LEDs of the first two columns, which the scan reaches.
  function automatic logic [7:0] pick_led();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) begin
      return 8'($urandom_range(0, 13));
    end else if (roll < 17) begin
      return 8'($urandom_range(0, 55));
    end
    return 8'($urandom_range(0, 239));
  endfunction

  function automatic logic [7:0] pick_brightness();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return 8'd0;
      1:       return 8'hff;
      2:       return 8'($urandom_range(1, 8));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly frame updates (writes, swap, ticks) and tick runs, with some noise.
  task automatic run_random(input int quota);
    int first;
    int roll;
    first = items_sent;
    while (items_sent - first < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        repeat ($urandom_range(1, 6)) send_word(FUNC_WRITE, pick_led(), pick_brightness());
        send_word(FUNC_SWAP, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(2, 20)) send_word(FUNC_TICK, 8'($urandom), 8'($urandom));
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 30)) send_word(FUNC_TICK, 8'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_word(FUNC_W'($urandom_range(0, 3)), 8'($urandom_range(0, 239)), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, writes outside the store, spare code, double swap at slot 0.
    send_word(FUNC_WRITE, 8'd0, 8'hff);
    send_word(FUNC_WRITE, 8'd1, 8'd1);
    send_word(FUNC_WRITE, 8'd2, 8'd0);
    send_word(FUNC_WRITE, 8'd6, 8'd128);
    send_word(FUNC_WRITE, 8'd55, 8'hff);
    send_word(FUNC_WRITE, 8'd56, 8'h77);
    send_word(FUNC_WRITE, 8'd239, 8'hff);
    send_word(FUNC_UNUSED, 8'd3, 8'h55);
    send_word(FUNC_SWAP, 8'd0, 8'd0);
    send_word(FUNC_SWAP, 8'hff, 8'hff);
    repeat (3) send_word(FUNC_TICK, 8'd0, 8'd0);
    send_word(FUNC_WRITE, 8'd3, 8'd200);
    send_word(FUNC_SWAP, 8'd0, 8'd0);
    repeat (3) send_word(FUNC_TICK, 8'hff, 8'hff);
    drain_results();

    // Directed: scanning off holds the counters and defers the swap.
    write_reg(CFG_SCAN_EN, 8'd0);
    send_word(FUNC_TICK, 8'd0, 8'd0);
    send_word(FUNC_SWAP, 8'd0, 8'd0);
    send_word(FUNC_WRITE, 8'd5, 8'd99);
    send_word(FUNC_TICK, 8'd0, 8'd0);
    drain_results();
    write_reg(CFG_SCAN_EN, 8'd1);

    // Random phases over a range of fitted LED counts.
    write_reg(CFG_NUM_LEDS, 8'd0);
    run_random(100);
    drain_results();
    write_reg(CFG_NUM_LEDS, 8'd240);
    run_random(150);
    drain_results();
    write_reg(CFG_NUM_LEDS, 8'($urandom_range(1, 13)));
    run_random(120);
    drain_results();
    write_reg(CFG_SCAN_EN, 8'd0);
    run_random(40);
    drain_results();
    write_reg(CFG_SCAN_EN, 8'd1);
    write_reg(CFG_NUM_LEDS, 8'd7);
    run_random(120);
    drain_results();
    write_reg(CFG_NUM_LEDS, NUM_LEDS_RESET);
    run_random(150);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d input words (%0d ticks), checked %0d result words;",
             items_sent, ticks_sent, words_checked);
    $display("LED counts 0 to 240, scanning on and off, swaps at column start.");
    if (mismatches == 0 && words_outstanding == 0) begin
      $display("tb_charlieplex_pwm_scanner_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, words_outstanding);
      $display("tb_charlieplex_pwm_scanner_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/cpx_pkg.sv
sv/cpx_frame_store.sv
sv/cpx_pin_drive.sv
sv/charlieplex_pwm_scanner_top.sv
verif/cpx_scan_checker.sv
verif/tb_charlieplex_pwm_scanner_top.sv
